### src/luhn_card_number_classifier_defines.svh
// Assertion macros for the Luhn card number classifier.
// Used by luhn_card_number_classifier.sv; expects clk and rst_n in scope.
`ifndef LUHN_CARD_NUMBER_CLASSIFIER_DEFINES_SVH
`define LUHN_CARD_NUMBER_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold on every clock edge out of reset.
`define LUHN_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("luhn classifier: invariant violated");

// Condition in one cycle implies a consequence in the next.
`define LUHN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("luhn classifier: sequencing violated");

`else

`define LUHN_ASSERT(lbl, prop)
`define LUHN_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### src/luhn_pkg.sv
// Types and constants for the Luhn card number classifier.
// No dependencies.
`timescale 1ns / 1ps

package luhn_pkg;

    localparam int NUM_W         = 63;              // card number width
    localparam int DIGITS        = 19;              // decimal digits that fit in NUM_W
    localparam int BCD_W         = 4 * DIGITS;
    localparam int BITS_PER_STEP = 4;               // binary bits folded in per cycle
    localparam int BIN_W         = 64;              // NUM_W padded to a step multiple
    localparam int CONV_STEPS    = BIN_W / BITS_PER_STEP;
    localparam int CONV_CNT_W    = $clog2(CONV_STEPS);
    localparam int SCAN_CNT_W    = $clog2(DIGITS);
    localparam int COUNT_W       = 5;
    localparam int LEAD_W        = 7;

    localparam logic [1:0] BRAND_INVALID = 2'd0;
    localparam logic [1:0] BRAND_FIFTEEN = 2'd1;    // 15 digits, 34 or 37
    localparam logic [1:0] BRAND_FIVES   = 2'd2;    // 16 digits, 51..55
    localparam logic [1:0] BRAND_FOUR    = 2'd3;    // 13 or 16 digits, leading 4

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    // Doubled digit with its decimal digits summed.
    function automatic logic [3:0] luhn_double(input logic [3:0] d);
        logic [4:0] p;
        begin
            p = {d, 1'b0};
            luhn_double = (p >= 5'd10) ? 4'(p - 5'd9) : p[3:0];
        end
    endfunction

endpackage

### src/luhn_card_number_classifier.sv
// Luhn mod-10 check and brand classification of a binary card number.
// Depends on luhn_pkg and luhn_card_number_classifier_defines.svh.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, card_number          | request in
//   out     | out_valid, out_stall, brand, luhn_ok,     | result out
//           | digit_count, leading_digits              |
//
// A new request is not accepted until the previous one is classified:
// binary-to-BCD conversion (4 bits per cycle through the add-3 adjust
// unit), a scan of one BCD digit per cycle through the digit adder, and
// a classification step that waits while a stalled result is held.
// Reset clears the sequencer and the output valid; no clearing pass.
// A stalled result sits in the output register while the next request runs.
`timescale 1ns / 1ps
`include "luhn_card_number_classifier_defines.svh"

module luhn_card_number_classifier
    import luhn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [NUM_W-1:0]     card_number,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           brand,
    output logic                 luhn_ok,
    output logic [COUNT_W-1:0]   digit_count,
    output logic [LEAD_W-1:0]    leading_digits
);

    state_t                  state_reg, state_next;
    logic [CONV_CNT_W-1:0]   conv_cnt_reg, conv_cnt_next;
    logic [SCAN_CNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic                    out_valid_reg, out_valid_next;

    logic [BIN_W-1:0]        bin_reg, bin_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic [3:0]              sum_reg, sum_next;      // running sum mod 10
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [LEAD_W-1:0]       lead_reg, lead_next;
    logic [3:0]              prev_reg, prev_next;

    logic [1:0]              brand_reg, brand_next;
    logic                    ok_reg, ok_next;
    logic [COUNT_W-1:0]      dcount_reg, dcount_next;
    logic [LEAD_W-1:0]       dlead_reg, dlead_next;

    logic                    accept;
    logic                    slot_free;
    logic [BCD_W-1:0]        dabble_bcd;
    logic [BIN_W-1:0]        dabble_bin;
    logic [3:0]              digit;
    logic [3:0]              digit_term;
    logic [4:0]              sum_raw;
    logic                    ok_final;
    logic                    lead_is_four;
    logic [1:0]              brand_final;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;

    // Double-dabble: fold BITS_PER_STEP bits into the BCD register.
    always_comb
    begin
        logic [BCD_W-1:0] b;
        logic [BIN_W-1:0] n;
        b = bcd_reg;
        n = bin_reg;
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            for (int k = 0; k < DIGITS; k++)
            begin
                if (b[4*k +: 4] >= 4'd5)
                begin
                    b[4*k +: 4] = b[4*k +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], n[BIN_W-1]};
            n = {n[BIN_W-2:0], 1'b0};
        end
        dabble_bcd = b;
        dabble_bin = n;
    end

    // Digit scan: low digit first, odd positions (0-based) doubled.
    assign digit      = bcd_reg[3:0];
    assign digit_term = scan_cnt_reg[0] ? luhn_double(digit) : digit;
    assign sum_raw    = {1'b0, sum_reg} + {1'b0, digit_term};

    assign ok_final     = (sum_reg == 4'd0);
    assign lead_is_four = (lead_reg == 7'd4) || ((lead_reg >= 7'd40) && (lead_reg <= 7'd49));

    always_comb
    begin
        brand_final = BRAND_INVALID;
        if (ok_final)
        begin
            if (count_reg == 5'd16)
            begin
                if ((lead_reg >= 7'd51) && (lead_reg <= 7'd55))
                begin
                    brand_final = BRAND_FIVES;
                end
                else if (lead_is_four)
                begin
                    brand_final = BRAND_FOUR;
                end
            end
            else if (count_reg == 5'd15)
            begin
                if ((lead_reg == 7'd34) || (lead_reg == 7'd37))
                begin
                    brand_final = BRAND_FIFTEEN;
                end
            end
            else if ((count_reg == 5'd13) && lead_is_four)
            begin
                brand_final = BRAND_FOUR;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        conv_cnt_next  = conv_cnt_reg;
        scan_cnt_next  = scan_cnt_reg;
        out_valid_next = out_valid_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        lead_next      = lead_reg;
        prev_next      = prev_reg;
        brand_next     = brand_reg;
        ok_next        = ok_reg;
        dcount_next    = dcount_reg;
        dlead_next     = dlead_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bin_next      = {{(BIN_W-NUM_W){1'b0}}, card_number};
                    bcd_next      = '0;
                    conv_cnt_next = '0;
                    state_next    = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bin_next      = dabble_bin;
                bcd_next      = dabble_bcd;
                conv_cnt_next = conv_cnt_reg + 1'b1;
                if (conv_cnt_reg == CONV_CNT_W'(CONV_STEPS - 1))
                begin
                    scan_cnt_next = '0;
                    sum_next      = '0;
                    count_next    = '0;
                    lead_next     = '0;
                    prev_next     = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                sum_next      = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
                bcd_next      = {4'd0, bcd_reg[BCD_W-1:4]};
                prev_next     = digit;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (digit != 4'd0)
                begin
                    count_next = COUNT_W'(scan_cnt_reg) + 1'b1;
                    if (scan_cnt_reg == '0)
                    begin
                        lead_next = LEAD_W'(digit);
                    end
                    else
                    begin
                        lead_next = (LEAD_W'(digit) << 3) + (LEAD_W'(digit) << 1)
                                    + LEAD_W'(prev_reg);
                    end
                end
                if (scan_cnt_reg == SCAN_CNT_W'(DIGITS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    brand_next     = brand_final;
                    ok_next        = ok_final;
                    dcount_next    = count_reg;
                    dlead_next     = lead_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            conv_cnt_reg  <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            conv_cnt_reg  <= conv_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        sum_reg    <= sum_next;
        count_reg  <= count_next;
        lead_reg   <= lead_next;
        prev_reg   <= prev_next;
        brand_reg  <= brand_next;
        ok_reg     <= ok_next;
        dcount_reg <= dcount_next;
        dlead_reg  <= dlead_next;
    end

    assign out_valid      = out_valid_reg;
    assign brand          = brand_reg;
    assign luhn_ok        = ok_reg;
    assign digit_count    = dcount_reg;
    assign leading_digits = dlead_reg;

    `LUHN_ASSERT_NEXT(a_accept_starts_conv, in_valid && !in_stall, state_reg == ST_CONV)
    `LUHN_ASSERT(a_brand_needs_ok, !(out_valid && (brand != BRAND_INVALID)) || luhn_ok)
    `LUHN_ASSERT(a_zero_has_no_lead, !(out_valid && (digit_count == '0)) || (leading_digits == '0))
    `LUHN_ASSERT_NEXT(a_done_frees_input, (state_reg == ST_DONE) && slot_free,
                      !in_stall && out_valid)

endmodule
